/* sv/tpmc_pkg.sv */
// ----------------------------------------------------------------------------
// tpmc_pkg
// Shared widths, register indexes, reset values and class codes for the
// two-photon mass classifier.
// ----------------------------------------------------------------------------
package tpmc_pkg;

  localparam int SQ_BITS        = 44;
  localparam int ROOT_BITS      = 23;
  localparam int ISQRT_STEPS    = SQ_BITS / 2;
  localparam int REG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int NUM_MESONS     = 3;
  localparam int CLASS_BITS     = 2;
  localparam int DIFF_BITS      = ROOT_BITS + 1;
  localparam int DIST_BITS      = ROOT_BITS + REG_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MASS_LIGHT       = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INV_WIDTH_LIGHT  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MASS_MIDDLE      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INV_WIDTH_MIDDLE = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MASS_HEAVY       = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INV_WIDTH_HEAVY  = 3'd5;

  localparam logic [REG_BITS-1:0] RST_MASS_LIGHT       = 16'd2160;
  localparam logic [REG_BITS-1:0] RST_INV_WIDTH_LIGHT  = 16'd3277;
  localparam logic [REG_BITS-1:0] RST_MASS_MIDDLE      = 16'd8720;
  localparam logic [REG_BITS-1:0] RST_INV_WIDTH_MIDDLE = 16'd1489;
  localparam logic [REG_BITS-1:0] RST_MASS_HEAVY       = 16'd15328;
  localparam logic [REG_BITS-1:0] RST_INV_WIDTH_HEAVY  = 16'd1092;

  localparam logic [CLASS_BITS-1:0] CLASS_PI0       = 2'd0;
  localparam logic [CLASS_BITS-1:0] CLASS_ETA       = 2'd1;
  localparam logic [CLASS_BITS-1:0] CLASS_ETA_PRIME = 2'd2;

endpackage

/* sv/tpmc_isqrt.sv */
// ----------------------------------------------------------------------------
// tpmc_isqrt
// Pipelined integer square root, one result bit per stage, with a side
// word carried alongside each operand.
// ----------------------------------------------------------------------------
module tpmc_isqrt import tpmc_pkg::*; #(
  parameter int SIDE_W = 44
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic [SQ_BITS-1:0]     in_mag,
  input  logic [SIDE_W-1:0]      in_side,
  output logic                   out_valid,
  output logic [ISQRT_STEPS-1:0] out_root,
  output logic [SIDE_W-1:0]      out_side
);

  logic               valid_q [ISQRT_STEPS];
  logic [SQ_BITS-1:0] rem_q   [ISQRT_STEPS];
  logic [SQ_BITS-1:0] root_q  [ISQRT_STEPS];
  logic [SIDE_W-1:0]  side_q  [ISQRT_STEPS];

  for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_step
    localparam logic [SQ_BITS-1:0] STEP_BIT = SQ_BITS'(1) << (2 * (ISQRT_STEPS - 1 - k));

    logic               valid_cur;
    logic [SQ_BITS-1:0] rem_cur;
    logic [SQ_BITS-1:0] root_cur;
    logic [SIDE_W-1:0]  side_cur;
    logic [SQ_BITS:0]   trial;

    if (k == 0) begin : g_first
      assign valid_cur = in_valid;
      assign rem_cur   = in_mag;
      assign root_cur  = '0;
      assign side_cur  = in_side;
    end else begin : g_next
      assign valid_cur = valid_q[k-1];
      assign rem_cur   = rem_q[k-1];
      assign root_cur  = root_q[k-1];
      assign side_cur  = side_q[k-1];
    end

    assign trial = {1'b0, root_cur} + {1'b0, STEP_BIT};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k] <= 1'b0;
      end else if (adv) begin
        valid_q[k] <= valid_cur;
        side_q[k]  <= side_cur;
        if ({1'b0, rem_cur} >= trial) begin
          rem_q[k]  <= rem_cur - trial[SQ_BITS-1:0];
          root_q[k] <= (root_cur >> 1) + STEP_BIT;
        end else begin
          rem_q[k]  <= rem_cur;
          root_q[k] <= root_cur >> 1;
        end
      end
    end
  end

  assign out_valid = valid_q[ISQRT_STEPS-1];
  assign out_root  = root_q[ISQRT_STEPS-1][ISQRT_STEPS-1:0];
  assign out_side  = side_q[ISQRT_STEPS-1];

endmodule

/* sv/two_photon_mass_classifier_top.sv */
// ----------------------------------------------------------------------------
// two_photon_mass_classifier_top
// Two-photon invariant mass, signed root and meson class, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one photon pair per clock while the result side is not stalled, and returns
// one result per pair, in order. Five stages form the summed four-vector,
// its squares, the saturated squared mass and its magnitude; the square root
// takes 22 stages, one root bit each; four stages form the signed root, the
// distances to the three configured masses and the class. A stall on the
// result side freezes the whole pipeline; one skid entry catches a pair that
// arrives in that cycle, and item_stall rises while it is occupied. Register
// writes are taken at any time (cfg_ready is always high) and apply to pairs
// in flight, so write them only while the block is empty.
// ----------------------------------------------------------------------------
module two_photon_mass_classifier_top import tpmc_pkg::*; #(
  parameter int COMPONENT_BITS = 20
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic signed [COMPONENT_BITS-1:0] energy_a,
  input  logic signed [COMPONENT_BITS-1:0] mom_x_a,
  input  logic signed [COMPONENT_BITS-1:0] mom_y_a,
  input  logic signed [COMPONENT_BITS-1:0] mom_z_a,
  input  logic signed [COMPONENT_BITS-1:0] energy_b,
  input  logic signed [COMPONENT_BITS-1:0] mom_x_b,
  input  logic signed [COMPONENT_BITS-1:0] mom_y_b,
  input  logic signed [COMPONENT_BITS-1:0] mom_z_b,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic signed [SQ_BITS-1:0]        mass_squared,
  output logic signed [ROOT_BITS-1:0]      mass_signed,
  output logic [CLASS_BITS-1:0]            meson_class,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic [REG_BITS-1:0]              cfg_data
);

  localparam int CB     = COMPONENT_BITS;
  localparam int SUM_W  = CB + 1;
  localparam int PROD_W = 2 * SUM_W;
  localparam int FW     = (PROD_W + 2 > SQ_BITS + 1) ? PROD_W + 2 : SQ_BITS + 1;

  localparam logic signed [FW-1:0] SAT_HI = {{(FW - SQ_BITS + 1){1'b0}}, {(SQ_BITS - 1){1'b1}}};
  localparam logic signed [FW-1:0] SAT_LO = {{(FW - SQ_BITS + 1){1'b1}}, {(SQ_BITS - 1){1'b0}}};

  // configuration
  logic [REG_BITS-1:0] ref_mass  [NUM_MESONS];
  logic [REG_BITS-1:0] inv_width [NUM_MESONS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_mass[0]  <= RST_MASS_LIGHT;
      inv_width[0] <= RST_INV_WIDTH_LIGHT;
      ref_mass[1]  <= RST_MASS_MIDDLE;
      inv_width[1] <= RST_INV_WIDTH_MIDDLE;
      ref_mass[2]  <= RST_MASS_HEAVY;
      inv_width[2] <= RST_INV_WIDTH_HEAVY;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MASS_LIGHT:       ref_mass[0]  <= cfg_data;
        REG_INV_WIDTH_LIGHT:  inv_width[0] <= cfg_data;
        REG_MASS_MIDDLE:      ref_mass[1]  <= cfg_data;
        REG_INV_WIDTH_MIDDLE: inv_width[1] <= cfg_data;
        REG_MASS_HEAVY:       ref_mass[2]  <= cfg_data;
        REG_INV_WIDTH_HEAVY:  inv_width[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // input skid and pipeline enable
  logic              adv;
  logic              skid_valid;
  logic [8*CB-1:0]   skid_bus;
  logic [8*CB-1:0]   in_bus;
  logic [8*CB-1:0]   head_bus;
  logic              head_valid;
  logic              in_take;

  assign adv        = !result_valid || !result_stall;
  assign item_stall = skid_valid;
  assign in_take    = item_valid && !skid_valid;
  assign in_bus     = {mom_z_b, mom_y_b, mom_x_b, energy_b, mom_z_a, mom_y_a, mom_x_a, energy_a};
  assign head_bus   = skid_valid ? skid_bus : in_bus;
  assign head_valid = skid_valid || in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (adv) begin
      skid_valid <= 1'b0;
    end else if (in_take) begin
      skid_valid <= 1'b1;
      skid_bus   <= in_bus;
    end
  end

  // S1: summed four-vector
  logic                    s1_valid;
  logic signed [SUM_W-1:0] s1_sum [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= head_valid;
      for (int k = 0; k < 4; k++) begin
        s1_sum[k] <= $signed({head_bus[k*CB + CB - 1], head_bus[k*CB +: CB]})
                   + $signed({head_bus[(k+4)*CB + CB - 1], head_bus[(k+4)*CB +: CB]});
      end
    end
  end

  // S2: squares
  logic                     s2_valid;
  logic signed [PROD_W-1:0] s2_sq [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
      for (int k = 0; k < 4; k++) begin
        s2_sq[k] <= PROD_W'(s1_sum[k]) * PROD_W'(s1_sum[k]);
      end
    end
  end

  // S3: partial sums
  logic                 s3_valid;
  logic signed [FW-1:0] s3_a;
  logic signed [FW-1:0] s3_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
      s3_a     <= FW'(s2_sq[0]) - FW'(s2_sq[1]);
      s3_b     <= FW'(s2_sq[2]) + FW'(s2_sq[3]);
    end
  end

  // S4: squared mass, saturated
  logic                      s4_valid;
  logic signed [SQ_BITS-1:0] s4_sq;
  logic signed [FW-1:0]      s3_diff;

  assign s3_diff = s3_a - s3_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
      if (s3_diff > SAT_HI) begin
        s4_sq <= SAT_HI[SQ_BITS-1:0];
      end else if (s3_diff < SAT_LO) begin
        s4_sq <= SAT_LO[SQ_BITS-1:0];
      end else begin
        s4_sq <= s3_diff[SQ_BITS-1:0];
      end
    end
  end

  // S5: magnitude
  logic               s5_valid;
  logic [SQ_BITS-1:0] s5_mag;
  logic [SQ_BITS-1:0] s5_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
      s5_mag   <= s4_sq[SQ_BITS-1] ? SQ_BITS'(-s4_sq) : s4_sq;
      s5_sq    <= s4_sq;
    end
  end

  // square root
  logic                   rt_valid;
  logic [ISQRT_STEPS-1:0] rt_root;
  logic [SQ_BITS-1:0]     rt_sq;

  tpmc_isqrt #(
    .SIDE_W (SQ_BITS)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s5_valid),
    .in_mag    (s5_mag),
    .in_side   (s5_sq),
    .out_valid (rt_valid),
    .out_root  (rt_root),
    .out_side  (rt_sq)
  );

  // C1: signed root
  logic                        c1_valid;
  logic signed [ROOT_BITS-1:0] c1_m;
  logic [SQ_BITS-1:0]          c1_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
    end else if (adv) begin
      c1_valid <= rt_valid;
      c1_m     <= rt_sq[SQ_BITS-1] ? -$signed({1'b0, rt_root}) : $signed({1'b0, rt_root});
      c1_sq    <= rt_sq;
    end
  end

  // C2: distance magnitudes
  logic                        c2_valid;
  logic [ROOT_BITS-1:0]        c2_abs [NUM_MESONS];
  logic signed [ROOT_BITS-1:0] c2_m;
  logic [SQ_BITS-1:0]          c2_sq;
  logic signed [DIFF_BITS-1:0] c1_diff [NUM_MESONS];

  always_comb begin
    for (int k = 0; k < NUM_MESONS; k++) begin
      c1_diff[k] = DIFF_BITS'(c1_m)
                 - $signed({{(DIFF_BITS - REG_BITS){1'b0}}, ref_mass[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_valid <= 1'b0;
    end else if (adv) begin
      c2_valid <= c1_valid;
      c2_m     <= c1_m;
      c2_sq    <= c1_sq;
      for (int k = 0; k < NUM_MESONS; k++) begin
        c2_abs[k] <= c1_diff[k][DIFF_BITS-1] ? ROOT_BITS'(-c1_diff[k])
                                              : c1_diff[k][ROOT_BITS-1:0];
      end
    end
  end

  // C3: width-scaled distances
  logic                        c3_valid;
  logic [DIST_BITS-1:0]        c3_dist [NUM_MESONS];
  logic signed [ROOT_BITS-1:0] c3_m;
  logic [SQ_BITS-1:0]          c3_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      c3_valid <= 1'b0;
    end else if (adv) begin
      c3_valid <= c2_valid;
      c3_m     <= c2_m;
      c3_sq    <= c2_sq;
      for (int k = 0; k < NUM_MESONS; k++) begin
        c3_dist[k] <= DIST_BITS'(c2_abs[k]) * DIST_BITS'(inv_width[k]);
      end
    end
  end

  // C4: class choice, ties go to the later candidate
  logic [CLASS_BITS-1:0] c3_class;

  always_comb begin
    if (c3_dist[0] < c3_dist[1]) begin
      c3_class = (c3_dist[0] < c3_dist[2]) ? CLASS_PI0 : CLASS_ETA_PRIME;
    end else begin
      c3_class = (c3_dist[1] < c3_dist[2]) ? CLASS_ETA : CLASS_ETA_PRIME;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= c3_valid;
      mass_squared <= c3_sq;
      mass_signed  <= c3_m;
      meson_class  <= c3_class;
    end
  end

`ifndef ASSERT_OFF
  a_root_sign: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (mass_squared[SQ_BITS-1] == mass_signed[ROOT_BITS-1]))
    else $error("root sign differs from squared mass sign");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !adv) |=> skid_valid)
    else $error("skid entry lost during stall");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && adv) |=> !skid_valid)
    else $error("skid entry not drained on advance");
`endif

endmodule
